// File: hw/rtl/cmeh_pkg.sv
// cmeh_pkg: shared types, constants and the arctangent table of the escape heading block
// used by cmeh_sqdiv, cmeh_cordic and costmap_escape_heading_top; depends on nothing

package cmeh_pkg;

	localparam int DEF_MAX_MAP_SIDE = 4096;
	localparam int DEF_MAX_RADIUS   = 255;

	// configuration register indexes
	localparam logic [2:0] REG_ROBOT_X  = 3'd0;
	localparam logic [2:0] REG_ROBOT_Y  = 3'd1;
	localparam logic [2:0] REG_RADIUS   = 3'd2;
	localparam logic [2:0] REG_COST_MIN = 3'd3;
	localparam logic [2:0] REG_MAP_W    = 3'd4;
	localparam logic [2:0] REG_MAP_H    = 3'd5;

	localparam logic [7:0]  COST_UNKNOWN = 8'd255;
	localparam logic [14:0] UNIT_MAX     = 15'd32767;

	localparam logic [4:0] SQRT_STEPS   = 5'd28;
	localparam logic [4:0] DIV_STEPS    = 5'd17;
	localparam logic [4:0] CORDIC_STEPS = 5'd21;

	localparam logic [21:0] PI_Q20      = 22'd3294199;
	localparam logic [21:0] HALF_PI_Q20 = 22'd1647099;
	localparam logic [15:0] HEAD_MAX    = 16'd25736;

	typedef enum logic [1:0] {
		OP_SQRT = 2'b01,
		OP_DIV  = 2'b10
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} sqdiv_ctl_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] heading;
	} head_res_t;

	function automatic logic [19:0] atan_q20(input logic [4:0] i);
		logic [19:0] v;
		unique case (i)
			5'd0:  v = 20'd823550;
			5'd1:  v = 20'd486170;
			5'd2:  v = 20'd256879;
			5'd3:  v = 20'd130396;
			5'd4:  v = 20'd65451;
			5'd5:  v = 20'd32757;
			5'd6:  v = 20'd16383;
			5'd7:  v = 20'd8192;
			5'd8:  v = 20'd4096;
			5'd9:  v = 20'd2048;
			5'd10: v = 20'd1024;
			5'd11: v = 20'd512;
			5'd12: v = 20'd256;
			5'd13: v = 20'd128;
			5'd14: v = 20'd64;
			5'd15: v = 20'd32;
			5'd16: v = 20'd16;
			5'd17: v = 20'd8;
			5'd18: v = 20'd4;
			5'd19: v = 20'd2;
			5'd20: v = 20'd1;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/cmeh_sqdiv.sv
// cmeh_sqdiv: shared shift and subtract unit, one result bit per cycle
// integer square root of a 56-bit value or division with a 17-bit quotient; uses cmeh_pkg

module cmeh_sqdiv (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmeh_pkg::sqdiv_ctl_t   ctl,
	input  logic [55:0]            num,
	input  logic [27:0]            den,
	output logic                   done,
	output logic [27:0]            result
);
	import cmeh_pkg::*;

	logic        busy_q;
	logic        done_q;
	op_t         op_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [55:0] src_q;
	logic [27:0] res_q;
	logic [27:0] den_q;

	logic [31:0] opa;
	logic [31:0] opb;
	logic [32:0] diff;
	logic        ge;
	logic [4:0]  last_cnt;

	// one compare and subtract serves both operations
	always_comb begin
		unique case (op_q)
			OP_SQRT: begin
				opa = {rem_q[29:0], src_q[55:54]};
				opb = {2'b00, res_q, 2'b01};
				last_cnt = SQRT_STEPS - 5'd1;
			end
			OP_DIV: begin
				opa = {rem_q[30:0], src_q[55]};
				opb = {4'b0000, den_q};
				last_cnt = DIV_STEPS - 5'd1;
			end
			default: begin
				opa = '0;
				opb = '0;
				last_cnt = '0;
			end
		endcase
		diff = {1'b0, opa} - {1'b0, opb};
		ge = !diff[32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_SQRT;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == last_cnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			res_q <= '0;
			den_q <= den;
			if (ctl.op == OP_DIV) begin
				// quotient fits in 17 bits, so the top of the dividend starts as remainder
				rem_q <= num[48:17];
				src_q <= {num[16:0], 39'd0};
			end else begin
				rem_q <= '0;
				src_q <= num;
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : opa;
			res_q <= {res_q[26:0], ge};
			src_q <= (op_q == OP_SQRT) ? {src_q[53:0], 2'b00} : {src_q[54:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: hw/rtl/cmeh_cordic.sv
// cmeh_cordic: four-quadrant arctangent of two 48-bit sums by CORDIC vectoring
// normalizes one bit a cycle, then one rotation a cycle; uses cmeh_pkg

module cmeh_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [47:0]  sx,
	input  logic signed [47:0]  sy,
	output cmeh_pkg::head_res_t res
);
	import cmeh_pkg::*;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_NORM = 4'b0010,
		C_ITER = 4'b0100,
		C_FIN  = 4'b1000
	} cstate_t;

	cstate_t            state_q;
	logic [47:0]        ax_q;
	logic [47:0]        ay_q;
	logic               sxn_q;
	logic               syn_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [22:0] z_q;
	logic [4:0]         i_q;
	logic               done_q;
	logic signed [15:0] head_q;

	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [22:0] da;
	logic [21:0]        zc;
	logic [21:0]        m;
	logic [22:0]        mr;
	logic [15:0]        r;
	logic [15:0]        rc;
	logic               big;

	always_comb begin
		dx  = y_q >>> i_q;
		dy  = x_q >>> i_q;
		da  = {3'b000, atan_q20(i_q)};
		big = (|ax_q[47:30]) || (|ay_q[47:30]);
		if (z_q < 0)
			zc = '0;
		else if (z_q > $signed({1'b0, HALF_PI_Q20}))
			zc = HALF_PI_Q20;
		else
			zc = z_q[21:0];
		m  = sxn_q ? (PI_Q20 - zc) : zc;
		mr = {1'b0, m} + 23'd64;
		r  = mr[22:7];
		rc = (r > HEAD_MAX) ? HEAD_MAX : r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: if (start) state_q <= C_NORM;
				C_NORM: if (!big) state_q <= C_ITER;
				C_ITER: if (i_q == CORDIC_STEPS - 5'd1) state_q <= C_FIN;
				C_FIN: begin
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (start) begin
					ax_q  <= sx[47] ? 48'(-sx) : sx;
					ay_q  <= sy[47] ? 48'(-sy) : sy;
					sxn_q <= sx[47];
					syn_q <= sy[47];
				end
			end
			C_NORM: begin
				if (big) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else begin
					x_q <= {4'b0000, ax_q[29:0]};
					y_q <= {4'b0000, ay_q[29:0]};
					z_q <= '0;
					i_q <= '0;
				end
			end
			C_ITER: begin
				if (y_q > 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + da;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - da;
				end
				i_q <= i_q + 5'd1;
			end
			C_FIN: head_q <= syn_q ? 16'(-rc) : rc;
			default: ;
		endcase
	end

	assign res.done    = done_q;
	assign res.heading = head_q;

endmodule

// File: hw/rtl/costmap_escape_heading_top.sv
// costmap_escape_heading_top: obstacle filter, repulsion sums and heading sequencer
// instantiates cmeh_sqdiv and cmeh_cordic; uses cmeh_pkg
//
// Usage: one map cell per input transfer (cell_col, cell_row, cell_cost, last_cell) on
// in_valid/in_stall. Cells that are off the map, outside the window, the robot cell, below
// cost_min or unknown stream at one per cycle while no other cell or heading is in work. An
// obstacle cell takes two squares and a sum on the shared multiplier, a square root and two
// divisions on the shared shift-subtract unit, then two multiply and saturating adds.
// in_stall is high while a cell or a heading is in work or a result waits to be emitted.
// The cell marked last_cell produces one result transfer (heading, heading_valid) on
// out_valid/out_stall after its own work, the normalize shifts and 21 CORDIC rotations;
// zero sums skip the rotations and give heading 0 and heading_valid 0 at once. The sums are
// cleared as the heading starts. The result sits in an output register: when the receiver
// stalls it holds there and the next cells are still taken; only a second result waits.
// Configuration writes on cfg_valid/cfg_ready are always taken (cfg_ready is tied high).
// Reset clears the sums, puts the registers at their defaults and empties the output.

module costmap_escape_heading_top #(
	parameter int MAX_MAP_SIDE = cmeh_pkg::DEF_MAX_MAP_SIDE,
	parameter int MAX_RADIUS   = cmeh_pkg::DEF_MAX_RADIUS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [20:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [11:0]        cell_col,
	input  logic [11:0]        cell_row,
	input  logic [7:0]         cell_cost,
	input  logic               last_cell,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] heading,
	output logic               heading_valid
);
	import cmeh_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE      = 16'h0001,
		S_SQX       = 16'h0002,
		S_SQY       = 16'h0004,
		S_SSUM      = 16'h0008,
		S_RT_GO     = 16'h0010,
		S_RT_WAIT   = 16'h0020,
		S_DX_GO     = 16'h0040,
		S_DX_WAIT   = 16'h0080,
		S_DY_GO     = 16'h0100,
		S_DY_WAIT   = 16'h0200,
		S_MULX      = 16'h0400,
		S_ADDX      = 16'h0800,
		S_ADDY      = 16'h1000,
		S_HEAD      = 16'h2000,
		S_HEAD_WAIT = 16'h4000,
		S_EMIT      = 16'h8000
	} state_t;

	state_t             state_q;
	logic signed [20:0] robot_x_q;
	logic signed [20:0] robot_y_q;
	logic [7:0]         radius_q;
	logic [7:0]         cost_min_q;
	logic [12:0]        map_w_q;
	logic [12:0]        map_h_q;

	logic [16:0]        ax_q;
	logic [16:0]        ay_q;
	logic               sgnx_q;
	logic               sgny_q;
	logic [7:0]         cost_q;
	logic               last_q;
	logic [34:0]        s_q;
	logic [33:0]        prod_q;
	logic [27:0]        d_q;
	logic [14:0]        qx_q;
	logic [14:0]        qy_q;
	logic signed [47:0] sum_x_q;
	logic signed [47:0] sum_y_q;
	logic signed [15:0] res_head_q;
	logic               res_ok_q;
	logic               out_valid_q;
	logic signed [15:0] heading_q;
	logic               heading_valid_q;

	logic signed [15:0] dc;
	logic signed [15:0] dr;
	logic signed [15:0] rad;
	logic [7:0]         rad8;
	logic [12:0]        mw;
	logic [12:0]        mh;
	logic signed [22:0] vx;
	logic signed [22:0] vy;
	logic [22:0]        vx_abs;
	logic [22:0]        vy_abs;
	logic               use_cell;
	logic               in_xfer;
	logic               emit;
	logic [16:0]        mul_a;
	logic [16:0]        mul_b;
	logic [33:0]        prod;
	sqdiv_ctl_t         sq_ctl;
	logic [55:0]        sq_num;
	logic               sq_done;
	logic [27:0]        sq_res;
	logic [14:0]        q_clamp;
	logic               sums_zero;
	head_res_t          head_res;

	// offset of a cell index from the robot cell, robot cell truncated toward zero
	function automatic logic signed [15:0] cell_off(input logic signed [20:0] pos,
			input logic [11:0] idx);
		logic signed [21:0] p;
		logic [21:0]        pa;
		logic [14:0]        t;
		logic signed [14:0] c;
		p  = {pos[20], pos};
		pa = p[21] ? 22'(-p) : p;
		t  = {1'b0, pa[21:8]};
		c  = p[21] ? 15'(-t) : t;
		return {4'b0000, idx} - {c[14], c};
	endfunction

	function automatic logic signed [47:0] sat_add(input logic signed [47:0] acc,
			input logic [22:0] mag, input logic neg);
		logic [48:0] add;
		logic [48:0] s;
		add = neg ? (49'd0 - {26'd0, mag}) : {26'd0, mag};
		s   = {acc[47], acc} + add;
		if (s[48] != s[47])
			return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		return s[47:0];
	endfunction

	// cell filter
	always_comb begin
		rad8 = (32'(radius_q) > MAX_RADIUS) ? 8'(MAX_RADIUS) : radius_q;
		mw   = (32'(map_w_q) > MAX_MAP_SIDE) ? 13'(MAX_MAP_SIDE) : map_w_q;
		mh   = (32'(map_h_q) > MAX_MAP_SIDE) ? 13'(MAX_MAP_SIDE) : map_h_q;
		rad  = {8'd0, rad8};
		dc   = cell_off(robot_x_q, cell_col);
		dr   = cell_off(robot_y_q, cell_row);
		vx   = {{2{robot_x_q[20]}}, robot_x_q} - {3'b000, cell_col, 8'h80};
		vy   = {{2{robot_y_q[20]}}, robot_y_q} - {3'b000, cell_row, 8'h80};
		vx_abs = vx[22] ? 23'(-vx) : vx;
		vy_abs = vy[22] ? 23'(-vy) : vy;
		use_cell = ({1'b0, cell_col} < mw) && ({1'b0, cell_row} < mh)
			&& (dc <= rad) && (dc >= -rad) && (dr <= rad) && (dr >= -rad)
			&& !(dc == 0 && dr == 0)
			&& (cell_cost >= cost_min_q) && (cell_cost != COST_UNKNOWN)
			&& !(vx == 0 && vy == 0);
	end

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign emit     = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	// shared multiplier
	always_comb begin
		unique case (state_q)
			S_SQX:   begin mul_a = ax_q; mul_b = ax_q; end
			S_SQY:   begin mul_a = ay_q; mul_b = ay_q; end
			S_MULX:  begin mul_a = {9'd0, cost_q}; mul_b = {2'b00, qx_q}; end
			S_ADDX:  begin mul_a = {9'd0, cost_q}; mul_b = {2'b00, qy_q}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		prod = mul_a * mul_b;
	end

	always_comb begin
		sq_ctl.start = (state_q == S_RT_GO) || (state_q == S_DX_GO) || (state_q == S_DY_GO);
		sq_ctl.op    = (state_q == S_RT_GO) ? OP_SQRT : OP_DIV;
		unique case (state_q)
			S_RT_GO: sq_num = {1'b0, s_q, 20'd0};
			S_DX_GO: sq_num = {14'd0, ax_q, 25'd0} + {29'd0, d_q[27:1]};
			S_DY_GO: sq_num = {14'd0, ay_q, 25'd0} + {29'd0, d_q[27:1]};
			default: sq_num = '0;
		endcase
		q_clamp = (sq_res > {13'd0, UNIT_MAX}) ? UNIT_MAX : sq_res[14:0];
		sums_zero = (sum_x_q == 0) && (sum_y_q == 0);
	end

	cmeh_sqdiv u_sqdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sq_ctl),
		.num    (sq_num),
		.den    (d_q),
		.done   (sq_done),
		.result (sq_res)
	);

	cmeh_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((state_q == S_HEAD) && !sums_zero),
		.sx     (sum_x_q),
		.sy     (sum_y_q),
		.res    (head_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_x_q  <= '0;
			robot_y_q  <= '0;
			radius_q   <= 8'd20;
			cost_min_q <= 8'd128;
			map_w_q    <= 13'd4096;
			map_h_q    <= 13'd4096;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROBOT_X:  robot_x_q  <= cfg_data;
				REG_ROBOT_Y:  robot_y_q  <= cfg_data;
				REG_RADIUS:   radius_q   <= cfg_data[7:0];
				REG_COST_MIN: cost_min_q <= cfg_data[7:0];
				REG_MAP_W:    map_w_q    <= cfg_data[12:0];
				REG_MAP_H:    map_h_q    <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// sequencer and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (use_cell)
							state_q <= S_SQX;
						else if (last_cell)
							state_q <= S_HEAD;
					end
				end
				S_SQX:     state_q <= S_SQY;
				S_SQY:     state_q <= S_SSUM;
				S_SSUM:    state_q <= S_RT_GO;
				S_RT_GO:   state_q <= S_RT_WAIT;
				S_RT_WAIT: if (sq_done) state_q <= S_DX_GO;
				S_DX_GO:   state_q <= S_DX_WAIT;
				S_DX_WAIT: if (sq_done) state_q <= S_DY_GO;
				S_DY_GO:   state_q <= S_DY_WAIT;
				S_DY_WAIT: if (sq_done) state_q <= S_MULX;
				S_MULX:    state_q <= S_ADDX;
				S_ADDX: begin
					sum_x_q <= sat_add(sum_x_q, prod_q[22:0], sgnx_q);
					state_q <= S_ADDY;
				end
				S_ADDY: begin
					sum_y_q <= sat_add(sum_y_q, prod_q[22:0], sgny_q);
					state_q <= last_q ? S_HEAD : S_IDLE;
				end
				S_HEAD: begin
					sum_x_q <= '0;
					sum_y_q <= '0;
					state_q <= sums_zero ? S_EMIT : S_HEAD_WAIT;
				end
				S_HEAD_WAIT: if (head_res.done) state_q <= S_EMIT;
				S_EMIT:      if (emit) state_q <= S_IDLE;
				default:     state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ax_q   <= vx_abs[16:0];
			ay_q   <= vy_abs[16:0];
			sgnx_q <= vx[22];
			sgny_q <= vy[22];
			cost_q <= cell_cost;
			last_q <= last_cell;
		end
		unique case (state_q)
			S_SQX:  prod_q <= prod;
			S_SQY: begin
				prod_q <= prod;
				s_q    <= {1'b0, prod_q};
			end
			S_SSUM: s_q <= s_q + {1'b0, prod_q};
			S_RT_WAIT: if (sq_done) d_q <= sq_res;
			S_DX_WAIT: if (sq_done) qx_q <= q_clamp;
			S_DY_WAIT: if (sq_done) qy_q <= q_clamp;
			S_MULX: prod_q <= prod;
			S_ADDX: prod_q <= prod;
			S_HEAD: begin
				res_head_q <= '0;
				res_ok_q   <= 1'b0;
			end
			S_HEAD_WAIT: begin
				if (head_res.done) begin
					res_head_q <= head_res.heading;
					res_ok_q   <= 1'b1;
				end
			end
			default: ;
		endcase
		if (emit) begin
			heading_q       <= res_head_q;
			heading_valid_q <= res_ok_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign heading       = heading_q;
	assign heading_valid = heading_valid_q;

	// the shift-subtract unit only finishes while the sequencer waits for it
	a_sqdiv_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == S_RT_WAIT || state_q == S_DX_WAIT || state_q == S_DY_WAIT))
		else $error("sqdiv result arrived outside a wait state");

	// sums are empty once a heading is launched
	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HEAD |=> (sum_x_q == 0 && sum_y_q == 0))
		else $error("sums not cleared after last cell");

	// a cell that is not the last never raises a result
	a_no_result_midscan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !last_cell && !out_valid_q) |=> !out_valid_q)
		else $error("result without last cell");

	// the heading unit only reports while the sequencer waits for it
	a_head_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		head_res.done |-> state_q == S_HEAD_WAIT)
		else $error("heading result arrived outside its wait state");

endmodule
